// ===== hw/rtl/gccd_pkg.sv =====
// Package: shared constants and G2 tap table for the Gold code correlation decoder.
`timescale 1ns / 1ps
`default_nettype none
package gccd_pkg;

  localparam int unsigned CODE_LEN     = 1023;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned SAT_W        = 5;
  localparam int unsigned THR_W        = 17;
  localparam int unsigned CORR_W       = 18;
  localparam int unsigned LFSR_W       = 10;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned DEF_NUM_SATS = 24;
  localparam int unsigned DEF_SAMPLE_W = 8;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(200);

  typedef struct packed {
    logic [3:0] tap_a;
    logic [3:0] tap_b;
  } g2_taps_t;

  // G2 output stage pair for each satellite (zero-based satellite index)
  function automatic g2_taps_t g2_taps(input logic [SAT_W-1:0] sat);
    g2_taps_t t;
    unique case (sat)
      5'd0:    t = '{4'd1, 4'd5};
      5'd1:    t = '{4'd2, 4'd6};
      5'd2:    t = '{4'd3, 4'd7};
      5'd3:    t = '{4'd4, 4'd8};
      5'd4:    t = '{4'd0, 4'd8};
      5'd5:    t = '{4'd1, 4'd9};
      5'd6:    t = '{4'd0, 4'd7};
      5'd7:    t = '{4'd1, 4'd8};
      5'd8:    t = '{4'd2, 4'd9};
      5'd9:    t = '{4'd1, 4'd2};
      5'd10:   t = '{4'd2, 4'd3};
      5'd11:   t = '{4'd4, 4'd5};
      5'd12:   t = '{4'd5, 4'd6};
      5'd13:   t = '{4'd6, 4'd7};
      5'd14:   t = '{4'd7, 4'd8};
      5'd15:   t = '{4'd8, 4'd9};
      5'd16:   t = '{4'd0, 4'd3};
      5'd17:   t = '{4'd1, 4'd4};
      5'd18:   t = '{4'd2, 4'd5};
      5'd19:   t = '{4'd3, 4'd6};
      5'd20:   t = '{4'd4, 4'd7};
      5'd21:   t = '{4'd5, 4'd8};
      5'd22:   t = '{4'd0, 4'd2};
      5'd23:   t = '{4'd3, 4'd5};
      default: t = '{4'd1, 4'd5};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gold_code_correlation_decoder.sv =====
// Top level: GPS C/A Gold code correlation decoder with one shared accumulator.
//
// Input stream (s_axis_*): one signed sample per item. The block stores 1023
// samples; while loading it is ready every cycle. The item that delivers the
// 1023rd sample starts a detection pass and tready drops until the pass ends.
// Per satellite: the Gold code is first generated into the chip memory, then
// each tested shift accumulates the 1023 stored samples through the single
// adder and the two registered memory reads, then one drain, one compare.
// The search for a satellite stops at the first shift whose sum passes the
// threshold, or after the last shift; its result then waits on the output.
// Output stream (m_axis_*): one result item per satellite, tlast on the
// final satellite. A result stays on the port until taken; the sequencer
// waits on a stalled receiver and loses nothing.
// Config: cfg_we_i writes detect_threshold (reset 200); write only when idle.
// Reset clears the sequencer and load count; sample and chip memories are not
// cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module gold_code_correlation_decoder #(
  parameter int unsigned NUM_SATELLITES = gccd_pkg::DEF_NUM_SATS,
  parameter int unsigned SAMPLE_BITS    = gccd_pkg::DEF_SAMPLE_W
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [gccd_pkg::THR_W-1:0]             cfg_wdata_i,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, rest zero
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // [4:0] satellite, [5] detected, [6] sent_bit, [16:7] code_phase,
  // [34:17] correlation, [39:35] zero
  output logic [gccd_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
  output logic                                        m_axis_tlast
);
  import gccd_pkg::*;

  localparam int unsigned ACC_W = SAMPLE_BITS + IDX_W;
  localparam int unsigned CMP_W = (ACC_W > CORR_W) ? ACC_W + 1 : CORR_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LEN - 1);
  localparam logic [SAT_W-1:0] LAST_SAT = SAT_W'(NUM_SATELLITES - 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BUILD,
    ST_ACC,
    ST_FLUSH,
    ST_CHECK,
    ST_OUT
  } state_e;

  state_e                   state_q;
  logic [IDX_W-1:0]         load_cnt_q;
  logic [IDX_W-1:0]         k_q;
  logic [IDX_W-1:0]         shift_q;
  logic [IDX_W-1:0]         start_q;
  logic [IDX_W-1:0]         caddr_q;
  logic [SAT_W-1:0]         sat_q;
  logic [LFSR_W-1:0]        g1_q;
  logic [LFSR_W-1:0]        g2_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     rd_vld_q;
  logic [THR_W-1:0]         thr_q;

  logic signed [SAMPLE_BITS-1:0] sample_mem [CODE_LEN];
  logic                          chip_mem   [CODE_LEN];
  logic signed [SAMPLE_BITS-1:0] samp_rd_q;
  logic                          chip_rd_q;

  logic [SAT_W-1:0]  res_sat_q;
  logic              res_det_q;
  logic              res_bit_q;
  logic [IDX_W-1:0]  res_phase_q;
  logic [CORR_W-1:0] res_corr_q;
  logic              res_last_q;

  g2_taps_t                 taps;
  logic                     chip_gen;
  logic                     g1_fb;
  logic                     g2_fb;
  logic                     in_fire;
  logic signed [CMP_W-1:0]  acc_ext;
  logic signed [CMP_W-1:0]  thr_ext;
  logic                     pass_pos;
  logic                     pass_neg;
  logic [IDX_W-1:0]         start_next;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign taps     = g2_taps(sat_q);
  assign chip_gen = g1_q[9] ^ g2_q[taps.tap_a] ^ g2_q[taps.tap_b];
  assign g1_fb    = g1_q[9] ^ g1_q[2];
  assign g2_fb    = g2_q[1] ^ g2_q[2] ^ g2_q[5] ^ g2_q[7] ^ g2_q[8] ^ g2_q[9];

  assign acc_ext  = CMP_W'(acc_q);
  assign thr_ext  = signed'(CMP_W'(thr_q));
  assign pass_pos = acc_ext > thr_ext;
  assign pass_neg = acc_ext < -thr_ext;
  // start chip address for the next shift: (-shift) mod 1023
  assign start_next = (start_q == '0) ? LAST_IDX : start_q - IDX_W'(1);

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tlast  = res_last_q;
  assign m_axis_tdata  = {5'b0, res_corr_q, res_phase_q, res_bit_q, res_det_q, res_sat_q};

  // memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_mem[load_cnt_q] <= signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
    end
    if (state_q == ST_BUILD) begin
      chip_mem[k_q] <= chip_gen;
    end
    samp_rd_q <= sample_mem[k_q];
    chip_rd_q <= chip_mem[caddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      k_q         <= '0;
      shift_q     <= '0;
      start_q     <= '0;
      caddr_q     <= '0;
      sat_q       <= '0;
      g1_q        <= '1;
      g2_q        <= '1;
      acc_q       <= '0;
      rd_vld_q    <= 1'b0;
      res_sat_q   <= '0;
      res_det_q   <= 1'b0;
      res_bit_q   <= 1'b0;
      res_phase_q <= '0;
      res_corr_q  <= '0;
      res_last_q  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_ACC);
      // shared adder: one stored sample per cycle, gated by its chip
      if (rd_vld_q && chip_rd_q) begin
        acc_q <= acc_q + ACC_W'(samp_rd_q);
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (load_cnt_q == LAST_IDX) begin
              load_cnt_q <= '0;
              sat_q      <= '0;
              k_q        <= '0;
              g1_q       <= '1;
              g2_q       <= '1;
              state_q    <= ST_BUILD;
            end else begin
              load_cnt_q <= load_cnt_q + IDX_W'(1);
            end
          end
        end
        ST_BUILD: begin
          g1_q <= {g1_q[LFSR_W-2:0], g1_fb};
          g2_q <= {g2_q[LFSR_W-2:0], g2_fb};
          if (k_q == LAST_IDX) begin
            k_q     <= '0;
            shift_q <= '0;
            start_q <= '0;
            caddr_q <= '0;
            acc_q   <= '0;
            state_q <= ST_ACC;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_ACC: begin
          caddr_q  <= (caddr_q == LAST_IDX) ? '0 : caddr_q + IDX_W'(1);
          if (k_q == LAST_IDX) begin
            k_q     <= '0;
            state_q <= ST_FLUSH;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (pass_pos || pass_neg || shift_q == LAST_IDX) begin
            res_sat_q   <= sat_q + SAT_W'(1);
            res_det_q   <= pass_pos || pass_neg;
            res_bit_q   <= pass_pos;
            res_phase_q <= (pass_pos || pass_neg) ? shift_q : '0;
            res_corr_q  <= (pass_pos || pass_neg) ? acc_ext[CORR_W-1:0] : '0;
            res_last_q  <= (sat_q == LAST_SAT);
            state_q     <= ST_OUT;
          end else begin
            shift_q <= shift_q + IDX_W'(1);
            start_q <= start_next;
            caddr_q <= start_next;
            acc_q   <= '0;
            state_q <= ST_ACC;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (sat_q == LAST_SAT) begin
              state_q <= ST_LOAD;
            end else begin
              sat_q   <= sat_q + SAT_W'(1);
              k_q     <= '0;
              g1_q    <= '1;
              g2_q    <= '1;
              state_q <= ST_BUILD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/gold_code_checker.sv =====
// Checker: predicts the satellite reports of the correlation decoder and compares them.
`timescale 1ns / 1ps
module gold_code_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gccd_pkg::THR_W-1:0]           cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  // [7:0] sample
  input  logic [7:0]                           s_axis_tdata,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [4:0] satellite, [5] detected, [6] sent_bit, [16:7] code_phase,
  // [34:17] correlation, [39:35] zero
  input  logic [gccd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 m_axis_tlast,
  output int                                   fail_count_o,
  output int                                   reports_pending_o,
  output int                                   reports_seen_o
);

  localparam int NUM_SATS = gccd_pkg::DEF_NUM_SATS;
  localparam int CODE_LEN = gccd_pkg::CODE_LEN;

  // G2 stage pair per satellite, zero-based
  localparam bit [3:0] TAP_A [NUM_SATS] = '{1, 2, 3, 4, 0, 1, 0, 1, 2, 1, 2, 4,
                                            5, 6, 7, 8, 0, 1, 2, 3, 4, 5, 0, 3};
  localparam bit [3:0] TAP_B [NUM_SATS] = '{5, 6, 7, 8, 8, 9, 7, 8, 9, 2, 3, 5,
                                            6, 7, 8, 9, 3, 4, 5, 6, 7, 8, 2, 5};

  typedef struct packed {
    logic [4:0]         sat;
    logic               detected;
    logic               sent_bit;
    logic [9:0]         phase;
    logic signed [17:0] corr;
    logic               last;
  } sat_report_t;

  bit                 gold_chips [NUM_SATS][CODE_LEN];
  logic signed [7:0]  sample_mem [CODE_LEN];
  int                 load_pos;
  int                 threshold;
  sat_report_t        reports_q [$];
  sat_report_t        want;
  sat_report_t        got;
  int                 fail_count;
  int                 reports_seen;

  assign fail_count_o      = fail_count;
  assign reports_pending_o = reports_q.size();
  assign reports_seen_o    = reports_seen;

  // C/A codes only depend on the tap pair, so build them once
  initial begin
    bit [9:0] g1;
    bit [9:0] g2;
    bit       f1;
    bit       f2;
    fail_count   = 0;
    reports_seen = 0;
    load_pos     = 0;
    threshold    = int'(gccd_pkg::THR_RESET);
    for (int s = 0; s < NUM_SATS; s++) begin
      g1 = '1;
      g2 = '1;
      for (int k = 0; k < CODE_LEN; k++) begin
        gold_chips[s][k] = g1[9] ^ g2[TAP_A[s]] ^ g2[TAP_B[s]];
        f1 = g1[9] ^ g1[2];
        f2 = g2[1] ^ g2[2] ^ g2[5] ^ g2[7] ^ g2[8] ^ g2[9];
        g1 = {g1[8:0], f1};
        g2 = {g2[8:0], f2};
      end
    end
  end

  task automatic search_all_satellites();
    sat_report_t r;
    int          acc;
    int          shift;
    bit          found;
    for (int s = 0; s < NUM_SATS; s++) begin
      r     = '0;
      found = 1'b0;
      for (shift = 0; shift < CODE_LEN && !found; shift++) begin
        acc = 0;
        for (int k = 0; k < CODE_LEN; k++) begin
          if (gold_chips[s][(k + CODE_LEN - shift) % CODE_LEN]) acc += int'(sample_mem[k]);
        end
        if (acc > threshold || acc < -threshold) begin
          found      = 1'b1;
          r.detected = 1'b1;
          r.sent_bit = acc > 0;
          r.phase    = 10'(shift);
          r.corr     = 18'(acc);
        end
      end
      r.sat  = 5'(s + 1);
      r.last = (s == NUM_SATS - 1);
      reports_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: report %0d, %s expected %0d, got %0d",
               $time, reports_seen, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      threshold = int'(gccd_pkg::THR_RESET);
      load_pos  = 0;
      reports_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sat      = m_axis_tdata[4:0];
        got.detected = m_axis_tdata[5];
        got.sent_bit = m_axis_tdata[6];
        got.phase    = m_axis_tdata[16:7];
        got.corr     = m_axis_tdata[34:17];
        got.last     = m_axis_tlast;
        if (reports_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected report, expected none, got satellite %0d",
                   $time, got.sat);
        end else begin
          want = reports_q.pop_front();
          check_field("satellite", want.sat, got.sat);
          check_field("detected", want.detected, got.detected);
          check_field("sent_bit", want.sent_bit, got.sent_bit);
          check_field("code_phase", want.phase, got.phase);
          check_field("correlation", want.corr, got.corr);
          check_field("tlast", want.last, got.last);
          check_field("padding", 0, m_axis_tdata[39:35]);
        end
        reports_seen++;
      end
      if (cfg_we_i) threshold = int'(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) begin
        sample_mem[load_pos] = s_axis_tdata;
        load_pos++;
        if (load_pos == CODE_LEN) begin
          load_pos = 0;
          search_all_satellites();
        end
      end
    end
  end

endmodule

// ===== bench/gold_code_correlation_decoder_tb.sv =====
// Testbench top: drives sample blocks and thresholds into the correlation decoder.
`timescale 1ns / 1ps
module gold_code_correlation_decoder_tb;

  localparam int CODE_LEN       = gccd_pkg::CODE_LEN;
  localparam int LIMIT_CYCLES   = 4_000_000;
  localparam int STRONG_THR     = 50000;
  localparam int PARTIAL_SPLIT  = 400;
  localparam int TAIL_SAMPLES   = 37;
  localparam logic [7:0] EDGE_SAMPLES [12] = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'h80,
                                                8'h7F, 8'hC0, 8'h40, 8'h55, 8'hAA, 8'h80};

  typedef enum {MIXED_LOAD, HIGH_LOAD, LOW_LOAD} load_kind_e;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [gccd_pkg::THR_W-1:0]          cfg_wdata_i = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  // [7:0] sample
  logic [7:0]                          s_axis_tdata = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  // [4:0] satellite, [5] detected, [6] sent_bit, [16:7] code_phase,
  // [34:17] correlation, [39:35] zero
  logic [gccd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
  logic                                m_axis_tlast;

  int          fail_count;
  int          reports_pending;
  int          reports_seen;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          samples_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  gold_code_correlation_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  gold_code_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tlast      (m_axis_tlast),
    .fail_count_o      (fail_count),
    .reports_pending_o (reports_pending),
    .reports_seen_o    (reports_seen)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d reports outstanding", $time, reports_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // entered after a posedge; leaves at the posedge where the item is taken
  task automatic push_sample(input logic [7:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
  endtask

  task automatic feed_samples(input load_kind_e kind, input int n);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      case (kind)
        HIGH_LOAD: v = 8'($urandom_range(127, 110));
        LOW_LOAD:  v = 8'(-int'($urandom_range(128, 110)));
        default:   v = 8'($urandom_range(255));
      endcase
      push_sample(v);
    end
  endtask

  task automatic write_threshold(input logic [gccd_pkg::THR_W-1:0] thr);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= thr;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
  endtask

  // stream stays quiet until all 24 reports are back, then a short hold-off
  task automatic await_reports();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reports_pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold, sample extremes up front, no idling
    foreach (EDGE_SAMPLES[i]) push_sample(EDGE_SAMPLES[i]);
    feed_samples(MIXED_LOAD, CODE_LEN - $size(EDGE_SAMPLES));
    await_reports();

    // strong positive block, sender idles
    src_idle_pct = 45;
    write_threshold(gccd_pkg::THR_W'(STRONG_THR));
    feed_samples(HIGH_LOAD, CODE_LEN);
    await_reports();

    // max threshold written before the block, then lowered mid-load before it completes
    src_idle_pct   = 0;
    sink_stall_pct = 45;
    write_threshold('1);
    feed_samples(LOW_LOAD, PARTIAL_SPLIT);
    write_threshold(gccd_pkg::THR_W'(STRONG_THR));
    feed_samples(LOW_LOAD, CODE_LEN - PARTIAL_SPLIT);
    await_reports();

    // zero threshold, both sides idle
    src_idle_pct   = 33;
    sink_stall_pct = 33;
    write_threshold('0);
    feed_samples(MIXED_LOAD, CODE_LEN);
    await_reports();

    // partial block left in the store at the end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    feed_samples(MIXED_LOAD, TAIL_SAMPLES);
    await_reports();
    repeat (16) @(negedge clk_i);

    $display("Summary: %0d samples streamed, %0d satellite reports checked", samples_sent,
             reports_seen);
    $display("Summary: thresholds 0, 200, 50000 and all-ones; mixed, high and low blocks");
    if (fail_count == 0 && reports_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
